[sv/tzpc_pkg.sv]
// Shared types and constants for the two-zone people counter.
// Depends on nothing; used by the top level.
package tzpc_pkg;

  localparam int WINDOW_DEPTH = 10;
  localparam int RAM_DEPTH    = 2 * WINDOW_DEPTH;
  localparam int ADDR_W       = $clog2(RAM_DEPTH);
  localparam int IDX_W        = $clog2(WINDOW_DEPTH);
  localparam int FILL_W       = $clog2(WINDOW_DEPTH + 1);
  localparam int DIST_W       = 16;

  localparam logic [DIST_W-1:0] FAR_MM        = 16'd2400;
  localparam logic [DIST_W-1:0] THRESHOLD_RST = 16'd1000;
  localparam logic [7:0]        CLOSE_MIN     = 8'((WINDOW_DEPTH + 1) / 2);
  localparam logic [7:0]        CLOSE_MAX     = 8'hFF;

  localparam logic [7:0] STATUS_OK        = 8'd0;
  localparam logic [7:0] STATUS_OK_ALT    = 8'd4;
  localparam logic [7:0] STATUS_OK_MERGED = 8'd7;

  localparam logic ZONE_LEFT  = 1'b0;
  localparam logic ZONE_RIGHT = 1'b1;

  localparam logic [1:0] PATH_LEFT  = 2'd1;
  localparam logic [1:0] PATH_RIGHT = 2'd2;
  localparam logic [1:0] PATH_BOTH  = 2'd3;

  localparam logic [2:0] PATH_START = 3'd1;
  localparam logic [2:0] PATH_FULL  = 3'd4;

  localparam logic [1:0] CROSS_NONE  = 2'd0;
  localparam logic [1:0] CROSS_ENTRY = 2'd1;
  localparam logic [1:0] CROSS_EXIT  = 2'd2;

  typedef struct packed {
    logic [7:0]        status_code;
    logic [DIST_W-1:0] distance_mm;
  } sample_t;

  typedef struct packed {
    logic [15:0] people_count;
    logic        next_zone;
    logic [1:0]  crossing;
    logic        zone_changed;
  } result_t;

endpackage

[sv/tzpc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; holds the per-zone distance windows.
module tzpc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 20
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/two_zone_people_counter.sv]
// Two-zone people counter: sliding-window minimum per zone, presence path, net count.
// Depends on tzpc_pkg and tzpc_ram.
//
//   channel  | handshake                    | payload
//   ---------+------------------------------+---------------------------
//   sample   | sample_valid / sample_stall  | tzpc_pkg::sample_t
//   result   | result_valid / result_stall  | tzpc_pkg::result_t
//   cfg      | cfg_valid / cfg_ready        | cfg_data, presence threshold
//
// Each request passes through an accept/write step (S_IDLE), a scan of every held window
// entry through the single min comparator on the RAM read port (S_SCAN), a drain step and
// a decide step; with fewer than two samples the scan and drain are skipped. A new sample
// is taken only in S_IDLE. Reset is synchronous and needs no clearing pass.
// A stalled result waits in its output register; the next request is taken meanwhile
// and its decide step holds until that register is free.
module two_zone_people_counter (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_stall,
  input  tzpc_pkg::sample_t sample,
  output logic              result_valid,
  input  logic              result_stall,
  output tzpc_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [15:0]       cfg_data
);
  import tzpc_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_DECIDE} state_t;

  state_t            state;
  logic [DIST_W-1:0] threshold;
  logic [FILL_W-1:0] window_fill [2];
  logic [IDX_W-1:0]  wr_ptr [2];
  logic [1:0]        path_codes [4];
  logic [2:0]        path_fill;
  logic              left_present;
  logic              right_present;
  logic [7:0]        close_count;
  logic              zone;
  logic [15:0]       total;
  logic [DIST_W-1:0] cur_mm;
  logic [DIST_W-1:0] min_dist;
  logic [IDX_W-1:0]  scan_idx;
  logic [IDX_W-1:0]  scan_last;
  logic              cmp_valid;

  logic              accept;
  logic              status_ok;
  logic [DIST_W-1:0] dist_in;
  logic [FILL_W-1:0] fill_next;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic [DIST_W-1:0] rdata;

  logic              present_now;
  logic              prev_present;
  logic              changed;
  logic [1:0]        code;
  logic              left_next;
  logic              right_next;
  logic [7:0]        close_next;
  logic [2:0]        path_fill_next;
  logic [1:0]        path_idx;
  logic              both_clear;
  logic [1:0]        xing;
  logic [15:0]       total_next;
  logic              out_free;

  assign accept       = sample_valid && !sample_stall;
  assign sample_stall = (state != S_IDLE);
  assign cfg_ready    = 1'b1;
  assign out_free     = !result_valid || !result_stall;

  assign status_ok = (sample.status_code == STATUS_OK) ||
                     (sample.status_code == STATUS_OK_ALT) ||
                     (sample.status_code == STATUS_OK_MERGED);
  assign dist_in   = (status_ok && sample.distance_mm != '0) ? sample.distance_mm : FAR_MM;

  assign fill_next = (window_fill[zone] < FILL_W'(WINDOW_DEPTH)) ?
                     window_fill[zone] + FILL_W'(1) : window_fill[zone];

  assign waddr = (zone == ZONE_RIGHT) ? ADDR_W'(WINDOW_DEPTH) + ADDR_W'(wr_ptr[zone])
                                      : ADDR_W'(wr_ptr[zone]);
  assign raddr = (zone == ZONE_RIGHT) ? ADDR_W'(WINDOW_DEPTH) + ADDR_W'(scan_idx)
                                      : ADDR_W'(scan_idx);

  tzpc_ram #(
    .WIDTH (DIST_W),
    .DEPTH (RAM_DEPTH)
  ) u_window (
    .clk   (clk),
    .we    (accept),
    .waddr (waddr),
    .wdata (dist_in),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    present_now = (min_dist < threshold);
    if (zone == ZONE_LEFT) begin
      prev_present = left_present;
      code         = {right_present, present_now};
      left_next    = present_now;
      right_next   = right_present;
    end else begin
      prev_present = right_present;
      code         = {present_now, left_present};
      left_next    = left_present;
      right_next   = present_now;
    end
    changed        = (present_now != prev_present);
    close_next     = (cur_mm < threshold && close_count != CLOSE_MAX) ?
                     close_count + 8'd1 : close_count;
    path_fill_next = (changed && path_fill != PATH_FULL) ? path_fill + 3'd1 : path_fill;
    path_idx       = 2'(path_fill_next - 3'd1);
    both_clear     = changed && !left_next && !right_next;
    xing           = CROSS_NONE;
    total_next     = total;
    if (both_clear && path_fill_next == PATH_FULL && close_next >= CLOSE_MIN) begin
      if (path_codes[1] == PATH_LEFT && path_codes[2] == PATH_BOTH &&
          path_codes[3] == PATH_RIGHT) begin
        xing       = CROSS_ENTRY;
        total_next = total + 16'd1;
      end else if (path_codes[1] == PATH_RIGHT && path_codes[2] == PATH_BOTH &&
                   path_codes[3] == PATH_LEFT) begin
        xing       = CROSS_EXIT;
        total_next = total - 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      threshold      <= THRESHOLD_RST;
      window_fill[0] <= '0;
      window_fill[1] <= '0;
      wr_ptr[0]      <= '0;
      wr_ptr[1]      <= '0;
      path_codes[0]  <= '0;
      path_codes[1]  <= '0;
      path_codes[2]  <= '0;
      path_codes[3]  <= '0;
      path_fill      <= PATH_START;
      left_present   <= 1'b0;
      right_present  <= 1'b0;
      close_count    <= '0;
      zone           <= ZONE_RIGHT;
      total          <= '0;
      cmp_valid      <= 1'b0;
      result_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        threshold <= cfg_data;
      end
      if (result_valid && !result_stall && state != S_DECIDE) begin
        result_valid <= 1'b0;
      end
      cmp_valid <= (state == S_SCAN);
      if (cmp_valid && rdata < min_dist) begin
        min_dist <= rdata;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cur_mm            <= dist_in;
            min_dist          <= FAR_MM;
            scan_idx          <= '0;
            scan_last         <= IDX_W'(fill_next - FILL_W'(1));
            window_fill[zone] <= fill_next;
            wr_ptr[zone]      <= (wr_ptr[zone] == IDX_W'(WINDOW_DEPTH - 1)) ?
                                 '0 : wr_ptr[zone] + IDX_W'(1);
            state             <= (fill_next >= FILL_W'(2)) ? S_SCAN : S_DECIDE;
          end
        end
        S_SCAN: begin
          if (scan_idx == scan_last) begin
            state <= S_DRAIN;
          end else begin
            scan_idx <= scan_idx + IDX_W'(1);
          end
        end
        S_DRAIN: begin
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (out_free) begin
            left_present  <= left_next;
            right_present <= right_next;
            path_fill     <= both_clear ? PATH_START : path_fill_next;
            close_count   <= both_clear ? '0 : close_next;
            total         <= total_next;
            if (both_clear) begin
              if (path_fill_next == PATH_FULL) begin
                window_fill[0] <= '0;
                window_fill[1] <= '0;
                wr_ptr[0]      <= '0;
                wr_ptr[1]      <= '0;
              end
            end else if (changed) begin
              path_codes[path_idx] <= code;
            end
            zone                <= ~zone;
            result_valid        <= 1'b1;
            result.people_count <= total_next;
            result.next_zone    <= ~zone;
            result.crossing     <= xing;
            result.zone_changed <= changed;
            state               <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_cross_needs_change: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.crossing != CROSS_NONE |-> result.zone_changed)
    else $error("crossing reported without a presence change");

  a_path_fill_range: assert property (@(posedge clk) disable iff (rst)
    path_fill != 3'd0 && path_fill <= PATH_FULL)
    else $error("path fill out of range");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    window_fill[0] <= FILL_W'(WINDOW_DEPTH) && window_fill[1] <= FILL_W'(WINDOW_DEPTH))
    else $error("window fill beyond depth");

  a_result_from_decide: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == S_DECIDE)
    else $error("result raised outside the decide step");

endmodule
